/* src/srb_pkg.sv */
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants
// Codes, register indexes and control bundles for the serial ring buffers.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam logic [1:0] OP_LINE_RX    = 2'd0;
  localparam logic [1:0] OP_TX_READY   = 2'd1;
  localparam logic [1:0] OP_HOST_READ  = 2'd2;
  localparam logic [1:0] OP_HOST_WRITE = 2'd3;

  localparam logic [7:0] CHAR_XON  = 8'd17;
  localparam logic [7:0] CHAR_XOFF = 8'd19;

  localparam logic [1:0] LO_NONE = 2'd0;
  localparam logic [1:0] LO_XON  = 2'd1;
  localparam logic [1:0] LO_XOFF = 2'd2;
  localparam logic [1:0] LO_DATA = 2'd3;

  localparam logic [1:0] REG_FLOW_EN  = 2'd0;
  localparam logic [1:0] REG_XOFF_THR = 2'd1;
  localparam logic [1:0] REG_XON_THR  = 2'd2;

  localparam logic [5:0] THR_RESET = 6'd16;

  typedef struct packed {
    logic       flow_enable;
    logic [5:0] xoff_free_threshold;
    logic [5:0] xon_fill_threshold;
  } cfg_t;

  typedef struct packed {
    logic rx_push;
    logic tx_push;
  } push_t;

  typedef struct packed {
    logic [1:0] lo_code;
    logic       rd_valid;
    logic       write_accepted;
    logic       rx_dropped;
    logic [5:0] rx_level;
    logic       tx_wanted;
  } res_t;

endpackage

/* src/serial_ring_buffers_xon_xoff_unit.sv */
// ----------------------------------------------------------------------------
// serial_ring_buffers_xon_xoff_unit: UART ring buffers with XON/XOFF
// Receive and transmit byte rings in block memory, with in-band flow control.
//
//   channel   handshake                      payload
//   command   start / busy                   op, data
//   result    done (strobe per beat)         line_out_valid .. tx_wanted
//   config    psel penable pwrite pready     paddr, pwdata, prdata
//
// One beat per clock while busy is low: a command taken at an edge has its
// result on the next cycle, set by the registered ring memory reads. Pointer
// writes and reads resolve at the accept edge, so back-to-back beats need no
// interlock. busy is high for the first cycle after reset only. Memory
// contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module serial_ring_buffers_xon_xoff_unit #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  data,
  output logic        done,
  output logic        line_out_valid,
  output logic [7:0]  line_out_byte,
  output logic [7:0]  read_byte,
  output logic        write_accepted,
  output logic        rx_dropped,
  output logic [5:0]  rx_level,
  output logic        tx_wanted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          accept, cfg_we;
  cfg_t          cfg;
  push_t         push;
  res_t          res;
  logic [AW-1:0] rx_wptr, rx_rptr, tx_wptr, tx_rptr;
  logic [7:0]    rx_rdata, tx_rdata;

  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy                    <= 1'b1;
      cfg.flow_enable         <= 1'b1;
      cfg.xoff_free_threshold <= THR_RESET;
      cfg.xon_fill_threshold  <= THR_RESET;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_FLOW_EN:  cfg.flow_enable         <= pwdata[0];
          REG_XOFF_THR: cfg.xoff_free_threshold <= pwdata[5:0];
          REG_XON_THR:  cfg.xon_fill_threshold  <= pwdata[5:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FLOW_EN:  prdata = {31'd0, cfg.flow_enable};
      REG_XOFF_THR: prdata = {26'd0, cfg.xoff_free_threshold};
      REG_XON_THR:  prdata = {26'd0, cfg.xon_fill_threshold};
      default:      prdata = '0;
    endcase
  end

  srb_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (op),
    .cfg     (cfg),
    .rx_wptr (rx_wptr),
    .rx_rptr (rx_rptr),
    .tx_wptr (tx_wptr),
    .tx_rptr (tx_rptr),
    .push    (push),
    .done    (done),
    .res     (res)
  );

  srb_ring #(.DEPTH(DEPTH), .AW(AW)) u_rx_ring (
    .clk   (clk),
    .we    (push.rx_push),
    .waddr (rx_wptr),
    .wdata (data),
    .re    (accept),
    .raddr (rx_rptr),
    .rdata (rx_rdata)
  );

  srb_ring #(.DEPTH(DEPTH), .AW(AW)) u_tx_ring (
    .clk   (clk),
    .we    (push.tx_push),
    .waddr (tx_wptr),
    .wdata (data),
    .re    (accept),
    .raddr (tx_rptr),
    .rdata (tx_rdata)
  );

  always_comb begin
    case (res.lo_code)
      LO_XON:  line_out_byte = CHAR_XON;
      LO_XOFF: line_out_byte = CHAR_XOFF;
      LO_DATA: line_out_byte = tx_rdata;
      default: line_out_byte = 8'd0;
    endcase
  end

  assign line_out_valid = (res.lo_code != LO_NONE);
  assign read_byte      = res.rd_valid ? rx_rdata : 8'd0;
  assign write_accepted = res.write_accepted;
  assign rx_dropped     = res.rx_dropped;
  assign rx_level       = res.rx_level;
  assign tx_wanted      = res.tx_wanted;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("result strobe missing after accepted beat");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done) else $error("result strobe without accepted beat");

  a_drop_on_line_rx: assert property (@(posedge clk) disable iff (rst)
    accept && op != OP_LINE_RX |=> !rx_dropped)
    else $error("drop flagged on a non line-receive beat");

  a_line_only_on_ready: assert property (@(posedge clk) disable iff (rst)
    accept && op != OP_TX_READY |=> !line_out_valid)
    else $error("line byte sent outside transmitter-ready beat");

endmodule

/* src/srb_ring.sv */
// ----------------------------------------------------------------------------
// srb_ring: ring storage
// One-write, one-read synchronous byte memory with registered read data.
// ----------------------------------------------------------------------------
module srb_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/srb_ctrl.sv */
// ----------------------------------------------------------------------------
// srb_ctrl: pointer and flow control
// Ring pointers, XON/XOFF flags and the registered status of each beat.
// ----------------------------------------------------------------------------
module srb_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          op,
  input  srb_pkg::cfg_t       cfg,
  output logic [AW-1:0]       rx_wptr,
  output logic [AW-1:0]       rx_rptr,
  output logic [AW-1:0]       tx_wptr,
  output logic [AW-1:0]       tx_rptr,
  output srb_pkg::push_t      push,
  output logic                done,
  output srb_pkg::res_t       res
);
  import srb_pkg::*;

  localparam int CW = ((AW > 6) ? AW : 6) + 1;
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);

  logic pending_xon, pending_xoff, peer_enabled, tx_request_enable;
  logic pending_xon_next, pending_xoff_next, peer_enabled_next, tx_request_enable_next;
  logic [AW-1:0] rx_wptr_next, rx_rptr_next, tx_wptr_next, tx_rptr_next;
  logic [AW:0]   rx_fill_w, tx_fill_w;
  logic [AW-1:0] rx_fill, tx_fill, rx_fill_after;
  logic [CW-1:0] rx_free_after, rx_fill_ext;
  logic          rx_full, rx_empty, tx_full, tx_empty;
  res_t          res_next;

  assign rx_fill_w = (rx_wptr >= rx_rptr) ? ({1'b0, rx_wptr} - {1'b0, rx_rptr})
                                          : ({1'b0, rx_wptr} + DEPTH_W - {1'b0, rx_rptr});
  assign tx_fill_w = (tx_wptr >= tx_rptr) ? ({1'b0, tx_wptr} - {1'b0, tx_rptr})
                                          : ({1'b0, tx_wptr} + DEPTH_W - {1'b0, tx_rptr});
  assign rx_fill  = rx_fill_w[AW-1:0];
  assign tx_fill  = tx_fill_w[AW-1:0];
  assign rx_full  = (rx_fill == LAST);
  assign tx_full  = (tx_fill == LAST);
  assign rx_empty = (rx_fill == '0);
  assign tx_empty = (tx_fill == '0);

  always_comb begin
    pending_xon_next       = pending_xon;
    pending_xoff_next      = pending_xoff;
    peer_enabled_next      = peer_enabled;
    tx_request_enable_next = tx_request_enable;
    rx_wptr_next           = rx_wptr;
    rx_rptr_next           = rx_rptr;
    tx_wptr_next           = tx_wptr;
    tx_rptr_next           = tx_rptr;
    rx_fill_after          = rx_fill;
    push                   = '0;
    res_next               = '0;

    case (op)
      OP_LINE_RX: begin
        if (!rx_full) begin
          push.rx_push  = accept;
          rx_wptr_next  = (rx_wptr == LAST) ? '0 : rx_wptr + 1'b1;
          rx_fill_after = rx_fill + 1'b1;
        end else begin
          res_next.rx_dropped = 1'b1;
        end
      end
      OP_TX_READY: begin
        if (cfg.flow_enable && pending_xon) begin
          res_next.lo_code  = LO_XON;
          pending_xon_next  = 1'b0;
          pending_xoff_next = 1'b0;
          peer_enabled_next = 1'b1;
        end else if (cfg.flow_enable && pending_xoff) begin
          res_next.lo_code  = LO_XOFF;
          pending_xon_next  = 1'b0;
          pending_xoff_next = 1'b0;
          peer_enabled_next = 1'b0;
        end else if (!tx_empty) begin
          res_next.lo_code = LO_DATA;
          tx_rptr_next     = (tx_rptr == LAST) ? '0 : tx_rptr + 1'b1;
        end else begin
          tx_request_enable_next = 1'b0;
        end
      end
      OP_HOST_READ: begin
        if (!rx_empty) begin
          res_next.rd_valid = 1'b1;
          rx_rptr_next      = (rx_rptr == LAST) ? '0 : rx_rptr + 1'b1;
          rx_fill_after     = rx_fill - 1'b1;
        end
      end
      default: begin
        if (!tx_full) begin
          push.tx_push            = accept;
          tx_wptr_next            = (tx_wptr == LAST) ? '0 : tx_wptr + 1'b1;
          res_next.write_accepted = 1'b1;
        end
        tx_request_enable_next = 1'b1;
      end
    endcase

    rx_fill_ext   = CW'(rx_fill_after);
    rx_free_after = CW'(LAST) - rx_fill_ext;

    if (op == OP_LINE_RX && cfg.flow_enable && peer_enabled &&
        rx_free_after < CW'(cfg.xoff_free_threshold)) begin
      pending_xoff_next      = 1'b1;
      pending_xon_next       = 1'b0;
      tx_request_enable_next = 1'b1;
    end
    if (op == OP_HOST_READ && cfg.flow_enable && !peer_enabled &&
        rx_fill_ext < CW'(cfg.xon_fill_threshold)) begin
      pending_xon_next       = 1'b1;
      pending_xoff_next      = 1'b0;
      tx_request_enable_next = 1'b1;
    end

    res_next.rx_level  = rx_fill_ext[5:0];
    res_next.tx_wanted = tx_request_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wptr           <= '0;
      rx_rptr           <= '0;
      tx_wptr           <= '0;
      tx_rptr           <= '0;
      pending_xon       <= 1'b1;
      pending_xoff      <= 1'b0;
      peer_enabled      <= 1'b0;
      tx_request_enable <= 1'b1;
      done              <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        rx_wptr           <= rx_wptr_next;
        rx_rptr           <= rx_rptr_next;
        tx_wptr           <= tx_wptr_next;
        tx_rptr           <= tx_rptr_next;
        pending_xon       <= pending_xon_next;
        pending_xoff      <= pending_xoff_next;
        peer_enabled      <= peer_enabled_next;
        tx_request_enable <= tx_request_enable_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule
